[hw/rtl/lkv_pkg.sv]
// ----------------------------------------------------------------------------
// LRU key-value store package
// Shared widths, register map, request codes and sequencer states.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int FIELD_W          = 32;
    localparam int DEF_ENTRIES      = 8;
    localparam int DEF_KEY_WIDTH    = 32;
    localparam int DEF_VALUE_WIDTH  = 32;

    localparam int CAP_W            = 4;
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;
    localparam logic [PADDR_W-3:0] REG_CAPACITY = 1'b0;

    localparam logic REQ_INSERT     = 1'b0;
    localparam logic REQ_TOUCH      = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

endpackage

[hw/rtl/lkv_if.sv]
// ----------------------------------------------------------------------------
// LRU key-value store channels
// Request and response valid/ready channels with their payload fields.
// ----------------------------------------------------------------------------
interface lkv_req_if;
    import lkv_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic [FIELD_W-1:0] req_key;
    logic [FIELD_W-1:0] req_value;

    modport source (output valid, output req_type, output req_key, output req_value,
                    input ready);
    modport sink   (input valid, input req_type, input req_key, input req_value,
                    output ready);
endinterface

interface lkv_rsp_if;
    import lkv_pkg::*;

    logic               valid;
    logic               ready;
    logic               hit;
    logic [FIELD_W-1:0] read_value;
    logic               evicted;
    logic [FIELD_W-1:0] evicted_key;
    logic [FIELD_W-1:0] evicted_value;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, output evicted_value, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, input evicted_value, output ready);
endinterface

[hw/rtl/lkv_ram.sv]
// ----------------------------------------------------------------------------
// LRU key-value store RAM
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/lru_key_value_store_unit.sv]
// ----------------------------------------------------------------------------
// LRU key-value store unit
// Fully associative key-value store with least-recently-used replacement.
//
// Usage:
//   i_req carries one request beat: insert (key, value) or touch (key).
//   o_rsp returns one response beat per request: hit and read value, or
//   the key and value of the entry evicted by an insert.
//   The APB port holds the capacity limit at byte address 0 (reset 8).
//   Keys and values sit in two RAMs that a single comparator walks, one
//   slot per cycle; recency ranks sit in flops and are updated at once.
//   The walk over the key RAM ends early when a touch or insert hits;
//   otherwise it covers every slot. One request is in flight at a time.
//   Reset empties the store at once: no clearing pass is needed.
//   A stalled response holds in the output register; the next request is
//   accepted meanwhile but its update waits until the held beat is taken.
// ----------------------------------------------------------------------------
module lru_key_value_store_unit #(
    parameter int ENTRIES     = lkv_pkg::DEF_ENTRIES,
    parameter int KEY_WIDTH   = lkv_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = lkv_pkg::DEF_VALUE_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lkv_req_if.sink                      i_req,
    lkv_rsp_if.source                    o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lkv_pkg::PADDR_W-1:0]  paddr,
    input  logic [lkv_pkg::PDATA_W-1:0]  pwdata,
    output logic [lkv_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import lkv_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int AGE_W = IDX_W;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int THR_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [THR_W-1:0] THR_NEW  = THR_W'(ENTRIES);

    t_state                 r_state, n_state;
    logic [CAP_W-1:0]       r_cap;
    logic [CNT_W-1:0]       r_held, n_held;
    logic [ENTRIES-1:0]     r_valid, n_valid;
    logic [AGE_W-1:0]       r_age [ENTRIES];
    logic [AGE_W-1:0]       n_age [ENTRIES];

    logic [IDX_W-1:0]       r_rd_idx, n_rd_idx;
    logic                   r_rd_done, n_rd_done;
    logic                   r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]       r_cmp_idx, n_cmp_idx;

    logic                   r_type, n_type;
    logic [KEY_WIDTH-1:0]   r_key, n_key;
    logic [VALUE_WIDTH-1:0] r_val, n_val;

    logic                   r_hit, n_hit;
    logic [IDX_W-1:0]       r_hit_idx, n_hit_idx;
    logic [VALUE_WIDTH-1:0] r_hit_val, n_hit_val;
    logic [AGE_W-1:0]       r_hit_age, n_hit_age;
    logic                   r_vic_found, n_vic_found;
    logic [IDX_W-1:0]       r_vic_idx, n_vic_idx;
    logic [KEY_WIDTH-1:0]   r_vic_key, n_vic_key;
    logic [VALUE_WIDTH-1:0] r_vic_val, n_vic_val;
    logic                   r_free_found, n_free_found;
    logic [IDX_W-1:0]       r_free_idx, n_free_idx;

    logic                   r_out_valid, n_out_valid;
    logic                   r_out_hit, n_out_hit;
    logic [FIELD_W-1:0]     r_out_read, n_out_read;
    logic                   r_out_ev, n_out_ev;
    logic [FIELD_W-1:0]     r_out_ek, n_out_ek;
    logic [FIELD_W-1:0]     r_out_evv, n_out_evv;

    logic [CNT_W-1:0]       cap_eff;
    logic [KEY_WIDTH-1:0]   key_q;
    logic [VALUE_WIDTH-1:0] val_q;
    logic                   key_we, val_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic                   cmp_match, cmp_victim;
    logic                   promo_en;
    logic [IDX_W-1:0]       promo_idx;
    logic [THR_W-1:0]       promo_thr;
    logic                   cfg_wr;

    lkv_ram #(.WIDTH(KEY_WIDTH), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_key),
        .i_raddr (r_rd_idx),
        .o_rdata (key_q)
    );

    lkv_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(ENTRIES)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_val),
        .i_raddr (r_rd_idx),
        .o_rdata (val_q)
    );

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1:2] == REG_CAPACITY) ? PDATA_W'(r_cap) : '0;

    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CNT_W'(1);
        end else if (int'(r_cap) > ENTRIES) begin
            cap_eff = CNT_W'(ENTRIES);
        end else begin
            cap_eff = CNT_W'(r_cap);
        end
    end

    assign cmp_match  = r_valid[r_cmp_idx] && (key_q == r_key);
    assign cmp_victim = r_valid[r_cmp_idx] &&
                        (CNT_W'(r_age[r_cmp_idx]) == r_held - CNT_W'(1));

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.read_value = r_out_read;
    assign o_rsp.evicted    = r_out_ev;
    assign o_rsp.evicted_key   = r_out_ek;
    assign o_rsp.evicted_value = r_out_evv;

    always_comb begin
        n_state      = r_state;
        n_held       = r_held;
        n_valid      = r_valid;
        n_age        = r_age;
        n_rd_idx     = r_rd_idx;
        n_rd_done    = r_rd_done;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_rd_idx;
        n_type       = r_type;
        n_key        = r_key;
        n_val        = r_val;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_val    = r_hit_val;
        n_hit_age    = r_hit_age;
        n_vic_found  = r_vic_found;
        n_vic_idx    = r_vic_idx;
        n_vic_key    = r_vic_key;
        n_vic_val    = r_vic_val;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_hit    = r_out_hit;
        n_out_read   = r_out_read;
        n_out_ev     = r_out_ev;
        n_out_ek     = r_out_ek;
        n_out_evv    = r_out_evv;
        key_we       = 1'b0;
        val_we       = 1'b0;
        ram_waddr    = r_hit_idx;
        promo_en     = 1'b0;
        promo_idx    = r_hit_idx;
        promo_thr    = {1'b0, r_hit_age};

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state      = S_SCAN;
                    n_type       = i_req.req_type;
                    n_key        = KEY_WIDTH'(i_req.req_key);
                    n_val        = VALUE_WIDTH'(i_req.req_value);
                    n_rd_idx     = '0;
                    n_rd_done    = 1'b0;
                    n_hit        = 1'b0;
                    n_vic_found  = 1'b0;
                    n_free_found = 1'b0;
                end
            end
            S_SCAN: begin
                if (!r_rd_done) begin
                    n_cmp_vld = 1'b1;
                    n_rd_idx  = r_rd_idx + IDX_W'(1);
                    if (r_rd_idx == LAST_IDX) begin
                        n_rd_done = 1'b1;
                    end
                end
                if (r_cmp_vld) begin
                    if (cmp_match) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_cmp_idx;
                        n_hit_val = val_q;
                        n_hit_age = r_age[r_cmp_idx];
                        n_state   = S_UPDATE;
                    end else if (r_cmp_idx == LAST_IDX) begin
                        n_state = S_UPDATE;
                    end
                    if (cmp_victim && !r_vic_found) begin
                        n_vic_found = 1'b1;
                        n_vic_idx   = r_cmp_idx;
                        n_vic_key   = key_q;
                        n_vic_val   = val_q;
                    end
                    if (!r_valid[r_cmp_idx] && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_cmp_idx;
                    end
                end
            end
            S_UPDATE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out_hit   = 1'b0;
                    n_out_read  = '0;
                    n_out_ev    = 1'b0;
                    n_out_ek    = '0;
                    n_out_evv   = '0;
                    if (r_hit) begin
                        n_out_hit = 1'b1;
                        promo_en  = 1'b1;
                        if (r_type == REQ_TOUCH) begin
                            n_out_read = FIELD_W'(r_hit_val);
                        end else begin
                            val_we = 1'b1;
                        end
                    end else if (r_type == REQ_INSERT) begin
                        if (r_held >= cap_eff && r_vic_found) begin
                            n_out_ev  = 1'b1;
                            n_out_ek  = FIELD_W'(r_vic_key);
                            n_out_evv = FIELD_W'(r_vic_val);
                            key_we    = 1'b1;
                            val_we    = 1'b1;
                            ram_waddr = r_vic_idx;
                            promo_en  = 1'b1;
                            promo_idx = r_vic_idx;
                            promo_thr = THR_W'(r_held - CNT_W'(1));
                        end else if (r_free_found) begin
                            key_we    = 1'b1;
                            val_we    = 1'b1;
                            ram_waddr = r_free_idx;
                            n_valid[r_free_idx] = 1'b1;
                            n_held    = r_held + CNT_W'(1);
                            promo_en  = 1'b1;
                            promo_idx = r_free_idx;
                            promo_thr = THR_NEW;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        for (int i = 0; i < ENTRIES; i++) begin
            if (promo_en) begin
                if (IDX_W'(i) == promo_idx) begin
                    n_age[i] = '0;
                end else if (r_valid[i] && ({1'b0, r_age[i]} < promo_thr)) begin
                    n_age[i] = r_age[i] + AGE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cap        <= CAP_RESET;
            r_held       <= '0;
            r_valid      <= '0;
            r_rd_idx     <= '0;
            r_rd_done    <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_hit        <= 1'b0;
            r_vic_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_held       <= n_held;
            r_valid      <= n_valid;
            r_rd_idx     <= n_rd_idx;
            r_rd_done    <= n_rd_done;
            r_cmp_vld    <= n_cmp_vld;
            r_hit        <= n_hit;
            r_vic_found  <= n_vic_found;
            r_free_found <= n_free_found;
            r_out_valid  <= n_out_valid;
            r_age        <= n_age;
            if (cfg_wr && paddr[PADDR_W-1:2] == REG_CAPACITY) begin
                r_cap <= pwdata[CAP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= n_cmp_idx;
        r_type     <= n_type;
        r_key      <= n_key;
        r_val      <= n_val;
        r_hit_idx  <= n_hit_idx;
        r_hit_val  <= n_hit_val;
        r_hit_age  <= n_hit_age;
        r_vic_idx  <= n_vic_idx;
        r_vic_key  <= n_vic_key;
        r_vic_val  <= n_vic_val;
        r_free_idx <= n_free_idx;
        r_out_hit  <= n_out_hit;
        r_out_read <= n_out_read;
        r_out_ev   <= n_out_ev;
        r_out_ek   <= n_out_ek;
        r_out_evv  <= n_out_evv;
    end

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(ENTRIES))
        else $error("held count above entry count");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.hit && o_rsp.evicted))
        else $error("response reports both hit and eviction");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_SCAN))
        else $error("accepted beat did not start a key walk");

    a_held_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != $past(r_held)) |-> (r_held == $past(r_held) + CNT_W'(1)))
        else $error("held count moved by other than one");
`endif
endmodule
